// ----- rtl/msq_pkg.sv -----
package msq_pkg;

  localparam int DATA_W = 32;
  localparam int DEFAULT_STACK_DEPTH = 32;

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_MIN  = 2'd2,
    FUNC_DUMP = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  // One stack entry: the stored value and the minimum of it and all below it.
  typedef struct packed {
    logic signed [DATA_W-1:0] elem;
    logic signed [DATA_W-1:0] rmin;
  } entry_t;

  // Shift commands broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
    logic rot;
  } cell_ctl_t;

endpackage

// ----- rtl/stack_with_minimum_query_core.sv -----
// Bounded LIFO stack of signed 32-bit words with a constant-time minimum
// query. The stack lives in a chain of identical cells, cell 0 being the top;
// every cell keeps its word together with the minimum of that word and all
// words below it, so a minimum query reads cell 0 only. Push, pop and minimum
// take one input word and give one result word, and a new input word can be
// taken every cycle as long as the result side does not stall. A dump gives
// one result word per stored element, top first, with last set on the bottom
// one; the chain rotates by one cell for each result word to bring each
// element to the top, and after a full turn the stack is back in its
// original order. No input word is taken while a dump is in progress. Pop,
// minimum or dump on an empty stack and push on a full stack give one result
// word with the empty or full status. Result words sit in a single output
// register; while a finished result waits there to be taken, the input is
// stalled as well.
module stack_with_minimum_query_core #(
  parameter int STACK_DEPTH = msq_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       func,
  input  logic signed [msq_pkg::DATA_W-1:0] push_value,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [msq_pkg::DATA_W-1:0] result_value,
  output logic [1:0]                       status,
  output logic                             last
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  // The chain of cells and its neighbor connections.
  msq_pkg::entry_t   chain [STACK_DEPTH];
  msq_pkg::entry_t   above [STACK_DEPTH];
  msq_pkg::entry_t   below [STACK_DEPTH];
  msq_pkg::entry_t   push_entry;
  msq_pkg::cell_ctl_t ctl;

  // Control registers.
  msq_pkg::state_t   state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  rem, rem_next;
  logic              out_valid_next;
  logic signed [msq_pkg::DATA_W-1:0] result_value_next;
  logic [1:0]        status_next;
  logic              last_next;

  logic              out_free;
  logic              is_full;
  logic              is_empty;
  msq_pkg::entry_t   top;

  assign top      = chain[0];
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state == msq_pkg::S_DUMP) || !out_free;
  assign is_full  = (count == CNT_W'(STACK_DEPTH));
  assign is_empty = (count == '0);

  // The new top entry carries the smaller of the pushed word and the minimum
  // held by the current top.
  always_comb begin
    push_entry.elem = push_value;
    if (!is_empty && (top.rmin < push_value)) begin
      push_entry.rmin = top.rmin;
    end else begin
      push_entry.rmin = push_value;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign above[gi] = push_entry;
      end else begin : g_inner
        assign above[gi] = chain[gi-1];
      end
      if (gi == STACK_DEPTH - 1) begin : g_last
        assign below[gi] = chain[gi];
      end else begin : g_body
        assign below[gi] = chain[gi+1];
      end

      msq_cell #(
        .IDX   (gi),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .count      (count),
        .from_above (above[gi]),
        .from_below (below[gi]),
        .from_top   (chain[0]),
        .held       (chain[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= msq_pkg::S_IDLE;
      count     <= '0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rem       <= rem_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    result_value <= result_value_next;
    status       <= status_next;
    last         <= last_next;
  end

  always_comb begin
    state_next        = state;
    count_next        = count;
    rem_next          = rem;
    out_valid_next    = out_valid && out_stall;
    result_value_next = result_value;
    status_next       = status;
    last_next         = last;
    ctl               = '0;

    unique case (state)
      msq_pkg::S_IDLE: begin
        if (in_valid && out_free) begin
          out_valid_next    = 1'b1;
          result_value_next = '0;
          status_next       = msq_pkg::ST_OK;
          last_next         = 1'b1;
          unique case (msq_pkg::func_t'(func))
            msq_pkg::FUNC_PUSH: begin
              if (is_full) begin
                status_next = msq_pkg::ST_FULL;
              end else begin
                ctl.push   = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            msq_pkg::FUNC_POP: begin
              if (is_empty) begin
                status_next = msq_pkg::ST_EMPTY;
              end else begin
                result_value_next = top.elem;
                ctl.pop           = 1'b1;
                count_next        = count - CNT_W'(1);
              end
            end
            msq_pkg::FUNC_MIN: begin
              if (is_empty) begin
                status_next = msq_pkg::ST_EMPTY;
              end else begin
                result_value_next = top.rmin;
              end
            end
            msq_pkg::FUNC_DUMP: begin
              if (is_empty) begin
                status_next = msq_pkg::ST_EMPTY;
              end else begin
                // The top word goes out now; the rest follow one per cycle while the result side does not stall.
                result_value_next = top.elem;
                ctl.rot           = 1'b1;
                if (count != CNT_W'(1)) begin
                  last_next  = 1'b0;
                  rem_next   = count - CNT_W'(1);
                  state_next = msq_pkg::S_DUMP;
                end
              end
            end
            default: begin
              status_next = msq_pkg::ST_OK;
            end
          endcase
        end
      end
      msq_pkg::S_DUMP: begin
        if (out_free) begin
          out_valid_next    = 1'b1;
          result_value_next = top.elem;
          status_next       = msq_pkg::ST_OK;
          ctl.rot           = 1'b1;
          rem_next          = rem - CNT_W'(1);
          if (rem == CNT_W'(1)) begin
            last_next  = 1'b1;
            state_next = msq_pkg::S_IDLE;
          end else begin
            last_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = msq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/msq_cell.sv -----
// One stack slot. Push moves entries one slot deeper, pop moves them one slot
// toward the top, and rotate does the same as pop except that the deepest
// occupied slot takes the top entry, so the stack comes back after a full turn.
module msq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  logic                clk,
  input  msq_pkg::cell_ctl_t  ctl,
  input  logic [CNT_W-1:0]    count,
  input  msq_pkg::entry_t     from_above,
  input  msq_pkg::entry_t     from_below,
  input  msq_pkg::entry_t     from_top,
  output msq_pkg::entry_t     held
);

  logic is_end;

  assign is_end = (count == CNT_W'(IDX + 1));

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      held <= from_above;
    end else if (ctl.pop) begin
      held <= from_below;
    end else if (ctl.rot) begin
      held <= is_end ? from_top : from_below;
    end
  end

endmodule

// ----- bench/stack_with_minimum_query_core_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the min-stack core. A behavioral copy of the stack
// lives in two queues here: the stored words and, beside each one, the
// minimum of that word and everything below it. Every input word accepted by
// the core is applied to that copy, and the result words it should cause are
// queued. A checker pops the oldest expected result word for every result
// word the core hands over and compares all three fields.
module stack_with_minimum_query_core_tb;

  localparam int DEPTH = msq_pkg::DEFAULT_STACK_DEPTH;
  // Long enough to cover a full dump under worst-case receiver stalls and
  // the deliberate hold-off below, with a wide margin on top.
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  // A dump of a full stack gives one result word per element, so this many idle
  // cycles at the end is enough for any stray result word to show up.
  localparam int SETTLE_CYCLES = DEPTH + 16;

  typedef struct {
    logic signed [msq_pkg::DATA_W-1:0] value;
    msq_pkg::status_t                  st;
    logic                              is_last;
  } result_word_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [1:0]                        func = msq_pkg::FUNC_PUSH;
  logic signed [msq_pkg::DATA_W-1:0] push_value = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [msq_pkg::DATA_W-1:0] result_value;
  logic [1:0]                        status;
  logic                              last;

  // Shadow of the stack: stored words and their running minimums, bottom
  // entry at index 0.
  logic signed [msq_pkg::DATA_W-1:0] stack_words[$];
  logic signed [msq_pkg::DATA_W-1:0] stack_mins[$];
  result_word_t                      expected_words[$];
  result_word_t                      oldest;

  // Idle behavior of both sides; zero means no idle cycles at all.
  int unsigned sender_gap_max = 16;
  int unsigned receiver_stall_max = 16;
  bit          hold_request = 1'b0;

  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned dumps_seen = 0;
  int unsigned full_pushes = 0;
  int unsigned empty_ops = 0;
  int unsigned quiet_cycles = 0;

  stack_with_minimum_query_core #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .push_value(push_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_value(result_value),
    .status(status),
    .last(last)
  );

  always #5 clk = ~clk;

  function automatic void expect_result(logic signed [msq_pkg::DATA_W-1:0] value,
                                        msq_pkg::status_t st, logic is_last);
    result_word_t r;
    r.value = value;
    r.st = st;
    r.is_last = is_last;
    expected_words.push_back(r);
  endfunction

  // Applies one accepted input word to the shadow stack and queues the
  // result words it must produce.
  function automatic void predict_stack_op(msq_pkg::func_t op,
                                           logic signed [msq_pkg::DATA_W-1:0] value);
    logic signed [msq_pkg::DATA_W-1:0] running_min;
    int i;
    if (op == msq_pkg::FUNC_PUSH) begin
      if (stack_words.size() >= DEPTH) begin
        full_pushes++;
        expect_result('0, msq_pkg::ST_FULL, 1'b1);
      end else begin
        running_min = value;
        if (stack_mins.size() > 0 && stack_mins[$] < value) running_min = stack_mins[$];
        stack_words.push_back(value);
        stack_mins.push_back(running_min);
        expect_result('0, msq_pkg::ST_OK, 1'b1);
      end
    end else if (stack_words.size() == 0) begin
      // Pop, minimum and dump all answer an empty stack the same way.
      empty_ops++;
      expect_result('0, msq_pkg::ST_EMPTY, 1'b1);
    end else begin
      case (op)
        msq_pkg::FUNC_POP: begin
          void'(stack_mins.pop_back());
          expect_result(stack_words.pop_back(), msq_pkg::ST_OK, 1'b1);
        end
        msq_pkg::FUNC_MIN: begin
          expect_result(stack_mins[$], msq_pkg::ST_OK, 1'b1);
        end
        default: begin
          // Dump runs from the top down; only the bottom word carries last.
          dumps_seen++;
          for (i = stack_words.size() - 1; i >= 0; i--) begin
            expect_result(stack_words[i], msq_pkg::ST_OK, i == 0);
          end
        end
      endcase
    end
  endfunction

  // Offers one input word after a random gap and returns in the time step
  // of the edge that accepted it. Valid is left high so that a following
  // word with no gap goes out back to back.
  task automatic send_word(msq_pkg::func_t op, logic signed [msq_pkg::DATA_W-1:0] value);
    int unsigned gap;
    gap = (sender_gap_max == 0) ? 0 : $urandom_range(0, sender_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= op;
    push_value <= value;
    do @(posedge clk); while (in_stall);
    words_sent++;
    predict_stack_op(op, value);
  endtask

  // Stops offering words until every expected result word has been taken.
  // At least one edge passes, so the next word is driven in a later step.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() > 0) @(posedge clk);
  endtask

  // Values lean toward the signed extremes and a narrow band around zero,
  // so that ties and sign changes in the running minimum come up often.
  function automatic logic signed [msq_pkg::DATA_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $signed($urandom_range(0, 16)) - 8;
      default: return $signed($urandom);
    endcase
  endfunction

  // Pushes are favored while the stack is shallow and pops while it is deep,
  // so the fill level wanders over its whole range.
  function automatic msq_pkg::func_t random_op();
    int unsigned push_pct;
    int unsigned r;
    if (stack_words.size() < 4) push_pct = 70;
    else if (stack_words.size() > DEPTH - 4) push_pct = 30;
    else push_pct = 50;
    r = $urandom_range(0, 99);
    if (r < push_pct) return msq_pkg::FUNC_PUSH;
    r = $urandom_range(0, 99);
    if (r < 45) return msq_pkg::FUNC_POP;
    if (r < 80) return msq_pkg::FUNC_MIN;
    return msq_pkg::FUNC_DUMP;
  endfunction

  // Every operation that needs a stored element is first tried with nothing
  // on the stack.
  task automatic test_empty_stack();
    send_word(msq_pkg::FUNC_POP, 32'sh12345678);
    send_word(msq_pkg::FUNC_MIN, 32'shffffffff);
    send_word(msq_pkg::FUNC_DUMP, '0);
  endtask

  // Signed extremes, alternating bit patterns, a tie on the minimum and a
  // dump of a few words. The stack ends empty again, with one last pop
  // hitting the empty case.
  task automatic test_extremes_and_ties();
    send_word(msq_pkg::FUNC_PUSH, 32'sh7fffffff);
    send_word(msq_pkg::FUNC_MIN, '0);
    send_word(msq_pkg::FUNC_PUSH, 32'sh80000000);
    send_word(msq_pkg::FUNC_MIN, '0);
    send_word(msq_pkg::FUNC_PUSH, 32'sh55555555);
    send_word(msq_pkg::FUNC_PUSH, 32'shaaaaaaaa);
    send_word(msq_pkg::FUNC_MIN, '0);
    send_word(msq_pkg::FUNC_DUMP, '0);
    send_word(msq_pkg::FUNC_POP, '0);
    send_word(msq_pkg::FUNC_POP, '0);
    send_word(msq_pkg::FUNC_MIN, '0);
    send_word(msq_pkg::FUNC_POP, '0);
    send_word(msq_pkg::FUNC_POP, '0);
    send_word(msq_pkg::FUNC_PUSH, -32'sd5);
    send_word(msq_pkg::FUNC_PUSH, -32'sd5);
    send_word(msq_pkg::FUNC_PUSH, 32'sd3);
    send_word(msq_pkg::FUNC_MIN, '0);
    send_word(msq_pkg::FUNC_POP, '0);
    send_word(msq_pkg::FUNC_POP, '0);
    send_word(msq_pkg::FUNC_MIN, '0);
    send_word(msq_pkg::FUNC_POP, '0);
    send_word(msq_pkg::FUNC_POP, '0);
  endtask

  // The receiver holds off for a long stretch while the sender keeps pushing
  // back to back. The result register fills, the core has to stall its
  // input, and the stack runs into the full case. A full dump follows.
  task automatic test_backpressure_fill();
    int k;
    wait_for_drain();
    sender_gap_max = 0;
    hold_request = 1'b1;
    for (k = 0; k < DEPTH + 2; k++) send_word(msq_pkg::FUNC_PUSH, random_value());
    sender_gap_max = 16;
    send_word(msq_pkg::FUNC_DUMP, '0);
    send_word(msq_pkg::FUNC_MIN, '0);
  endtask

  // The bulk of the run: random operations in phases that vary how often
  // each side idles, with a full drain pause in the middle.
  task automatic test_random_ops();
    int phase;
    int k;
    int unsigned gap_by_phase[6] = '{16, 0, 0, 16, 4, 16};
    int unsigned stall_by_phase[6] = '{16, 0, 16, 0, 4, 16};
    for (phase = 0; phase < 6; phase++) begin
      sender_gap_max = gap_by_phase[phase];
      receiver_stall_max = stall_by_phase[phase];
      for (k = 0; k < 20; k++) send_word(random_op(), random_value());
      if (phase == 2) wait_for_drain();
    end
    receiver_stall_max = 16;
  endtask

  // Receiver: draws a stall length for every result word, or serves one long
  // hold-off when the test asks for it, then waits for the next word.
  initial begin
    int unsigned stall;
    wait (rst == 1'b0);
    forever begin
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end else if (receiver_stall_max == 0) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, receiver_stall_max);
      end
      if (stall > 0) begin
        out_stall <= 1'b1;
        repeat (stall) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Every word taken from the core is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: value %0d status %0d last %0d",
                 $time, result_value, status, last);
      end else begin
        oldest = expected_words.pop_front();
        if (result_value !== oldest.value) begin
          errors++;
          $display("%0t: result_value mismatch: expected %0d, got %0d",
                   $time, oldest.value, result_value);
        end
        if (status !== oldest.st) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, got %0d", $time, oldest.st, status);
        end
        if (last !== oldest.is_last) begin
          errors++;
          $display("%0t: last mismatch: expected %0d, got %0d", $time, oldest.is_last, last);
        end
      end
    end
  end

  // Watchdog: a run in which neither side moves a word for this long is hung.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d result words still expected",
               $time, QUIET_LIMIT, expected_words.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_empty_stack();
    test_extremes_and_ties();
    test_backpressure_fill();
    test_random_ops();

    // Let everything drain, then give the core time to emit anything extra.
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_words.size() > 0) begin
      errors++;
      $display("%0t: %0d expected result words never arrived", $time, expected_words.size());
    end

    $display("Sent %0d input words and checked %0d result words.", words_sent, results_seen);
    $display("That included %0d dumps, %0d pushes on a full stack and %0d empty-stack ops.",
             dumps_seen, full_pushes, empty_ops);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/msq_pkg.sv
rtl/msq_cell.sv
rtl/stack_with_minimum_query_core.sv
bench/stack_with_minimum_query_core_tb.sv
